@@ rtl/rne_pkg.sv @@
// ----------------------------------------------------------------------------
// rne_pkg
// shared constants, control word layout and the microcode table of the
// roman numeral encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

  localparam int DefValueBits = 12;
  localparam int MaxChars     = 15;
  localparam int TableLen     = 13;
  localparam int StepBits     = 4;
  localparam int CntBits      = 4;
  localparam int WeightBits   = 10;

  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChV = 8'h56;
  localparam logic [7:0] ChX = 8'h58;
  localparam logic [7:0] ChL = 8'h4C;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChNone = 8'h00;

  // one control word per program step
  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [7:0]            glyph0;
    logic [7:0]            glyph1;
    logic                  pair;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic                  load;
    logic                  sub;
    logic [WeightBits-1:0] weight;
    logic                  emit;
    logic [7:0]            symbol;
    logic                  last;
    logic                  empty;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic                in_zero;
    logic                rest_n_zero;
    logic [StepBits-1:0] next_step;
  } stat_t;

  function automatic uword_t ucode(input logic [StepBits-1:0] step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{weight: 10'd1000, glyph0: ChM, glyph1: ChNone, pair: 1'b0};
      4'd1:    w = '{weight: 10'd900,  glyph0: ChC, glyph1: ChM,    pair: 1'b1};
      4'd2:    w = '{weight: 10'd500,  glyph0: ChD, glyph1: ChNone, pair: 1'b0};
      4'd3:    w = '{weight: 10'd400,  glyph0: ChC, glyph1: ChD,    pair: 1'b1};
      4'd4:    w = '{weight: 10'd100,  glyph0: ChC, glyph1: ChNone, pair: 1'b0};
      4'd5:    w = '{weight: 10'd90,   glyph0: ChX, glyph1: ChC,    pair: 1'b1};
      4'd6:    w = '{weight: 10'd50,   glyph0: ChL, glyph1: ChNone, pair: 1'b0};
      4'd7:    w = '{weight: 10'd40,   glyph0: ChX, glyph1: ChL,    pair: 1'b1};
      4'd8:    w = '{weight: 10'd10,   glyph0: ChX, glyph1: ChNone, pair: 1'b0};
      4'd9:    w = '{weight: 10'd9,    glyph0: ChI, glyph1: ChX,    pair: 1'b1};
      4'd10:   w = '{weight: 10'd5,    glyph0: ChV, glyph1: ChNone, pair: 1'b0};
      4'd11:   w = '{weight: 10'd4,    glyph0: ChI, glyph1: ChV,    pair: 1'b1};
      default: w = '{weight: 10'd1,    glyph0: ChI, glyph1: ChNone, pair: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rne_datapath.sv @@
// ----------------------------------------------------------------------------
// rne_datapath
// remainder register, weight subtractor, next-step search and the
// registered result ports
// ----------------------------------------------------------------------------
`default_nettype none

module rne_datapath import rne_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire ctrl_t                 ctrl_i,
  output      stat_t                 stat_o,
  output      logic                  valid_o,
  output      logic [7:0]            symbol_o,
  output      logic                  last_o,
  output      logic                  empty_res_o
);

  logic [VALUE_BITS-1:0] rest_q, rest_d;
  logic [VALUE_BITS-1:0] rest_n;
  logic [VALUE_BITS-1:0] src;
  logic [StepBits-1:0]   next_step;
  uword_t                probe;
  logic                  valid_q;
  logic [7:0]            symbol_q;
  logic                  last_q;
  logic                  empty_q;

  assign rest_n = rest_q - VALUE_BITS'(ctrl_i.weight);
  assign src    = ctrl_i.load ? value_i : rest_n;

  // conditional jump target: first table entry that still fits
  always_comb begin
    next_step = StepBits'(TableLen - 1);
    probe     = ucode(StepBits'(TableLen - 1));
    for (int i = TableLen - 1; i >= 0; i--) begin
      probe = ucode(StepBits'(i));
      if (src >= VALUE_BITS'(probe.weight)) begin
        next_step = StepBits'(i);
      end
    end
  end

  always_comb begin
    rest_d = rest_q;
    if (ctrl_i.load) begin
      rest_d = value_i;
    end else if (ctrl_i.sub) begin
      rest_d = rest_n;
    end
  end

  assign stat_o = '{in_zero:     (value_i == '0),
                    rest_n_zero: (rest_n == '0),
                    next_step:   next_step};

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    if (ctrl_i.emit) begin
      symbol_q <= ctrl_i.symbol;
      last_q   <= ctrl_i.last;
      empty_q  <= ctrl_i.empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit;
    end
  end

  assign valid_o     = valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule

`default_nettype wire

@@ rtl/rne_sequencer.sv @@
// ----------------------------------------------------------------------------
// rne_sequencer
// step counter over the microcode table, pair phase and character count
// ----------------------------------------------------------------------------
`default_nettype none

module rne_sequencer import rne_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire stat_t stat_i,
  output      ctrl_t ctrl_o,
  output      logic  busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [StepBits-1:0] step_q, step_d;
  logic                phase_q, phase_d;
  logic [CntBits-1:0]  count_q, count_d;
  uword_t              uw;
  logic                end_entry;

  assign uw        = ucode(step_q);
  assign end_entry = !uw.pair || phase_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    phase_d = phase_q;
    count_d = count_q;
    ctrl_o  = '{load: 1'b0, sub: 1'b0, weight: uw.weight, emit: 1'b0,
                symbol: ChNone, last: 1'b0, empty: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          if (stat_i.in_zero) begin
            ctrl_o.emit  = 1'b1;
            ctrl_o.last  = 1'b1;
            ctrl_o.empty = 1'b1;
          end else begin
            state_d = ST_EMIT;
            step_d  = stat_i.next_step;
            phase_d = 1'b0;
            count_d = '0;
          end
        end
      end
      ST_EMIT: begin
        ctrl_o.emit   = 1'b1;
        ctrl_o.symbol = phase_q ? uw.glyph1 : uw.glyph0;
        ctrl_o.sub    = end_entry;
        // numeral done, or cut at the character limit
        ctrl_o.last   = (end_entry && stat_i.rest_n_zero) ||
                        (count_q == CntBits'(MaxChars - 1));
        count_d = count_q + 1'b1;
        if (ctrl_o.last) begin
          state_d = ST_IDLE;
        end else if (end_entry) begin
          step_d  = stat_i.next_step;
          phase_d = 1'b0;
        end else begin
          phase_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      phase_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign busy = (state_q == ST_EMIT);

endmodule

`default_nettype wire

@@ rtl/roman_numeral_encoder.sv @@
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// renders an unsigned binary value as a run of roman numeral characters
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; value_i
// is sampled there. The numeral then leaves one ASCII character per cycle
// on symbol_o, marked by valid_o for exactly one cycle, with last_o on the
// final character. Values of 4000 and up get extra leading M characters;
// output is cut after 15 characters, the fifteenth carrying last_o.
// A zero value gives a single result with empty_res_o and last_o set and
// symbol_o at zero in the cycle after the request, and busy stays low.
// For a nonzero value the sequencer first enters its emit state and the
// result registers then capture each character; busy is high while
// characters are produced. The pace is set by the microcoded sequencer,
// which emits one character per step and jumps to the next fitting table
// entry in the same step.
// The receiver cannot stall: every result is valid for one cycle only.
// Reset clears the sequencer and the result strobe; no request is pending
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder import rne_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output      logic                  valid_o,
  output      logic [7:0]            symbol_o,
  output      logic                  last_o,
  output      logic                  empty_res_o
);

  ctrl_t ctrl;
  stat_t stat;

  rne_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  rne_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule

`default_nettype wire

@@ rtl/rne_checker.sv @@
// ----------------------------------------------------------------------------
// rne_checker
// port-level checks of the roman numeral encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rne_checker import rne_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [VALUE_BITS-1:0] value_i,
  input wire logic                  valid_o,
  input wire logic [7:0]            symbol_o,
  input wire logic                  last_o,
  input wire logic                  empty_res_o
);

  // a zero request is answered with a single empty result
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && value_i == '0) |=> (valid_o && last_o && empty_res_o))
    else $error("zero request did not give an empty result");

  // a nonzero request shows nothing in the next cycle
  a_nonzero_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && value_i != '0) |=> !valid_o)
    else $error("result right after a nonzero request");

  // empty result is the whole numeral and carries no character
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_res_o) |-> (last_o && symbol_o == ChNone))
    else $error("malformed empty result");

  // more characters to come means the block is still busy
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("not busy in the middle of a numeral");

  // characters are roman symbols only
  a_symbol_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !empty_res_o) |-> (symbol_o == ChI || symbol_o == ChV ||
      symbol_o == ChX || symbol_o == ChL || symbol_o == ChC ||
      symbol_o == ChD || symbol_o == ChM))
    else $error("symbol outside the roman set");

endmodule

bind roman_numeral_encoder rne_checker #(.VALUE_BITS(VALUE_BITS)) u_rne_checker (.*);

`default_nettype wire
